@@ rtl/ihex_pkg.sv @@
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants for the hex record parser
// Parse phases, result codes, parser state and result records, and the
// hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_SKIP       = 4'd1,
        PH_COUNT      = 4'd2,
        PH_ADDR_HI    = 4'd3,
        PH_ADDR_LO    = 4'd4,
        PH_TYPE       = 4'd5,
        PH_DATA       = 4'd6,
        PH_CHECK      = 4'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_ACCEPT  = 3'd1,
        ST_FMT_ERR = 3'd2,
        ST_SUM_ERR = 3'd3,
        ST_END     = 3'd4
    } t_status;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] DATA_KIND  = 8'h00;

    typedef struct packed {
        t_phase      phase;
        logic        nib_pend;
        logic [3:0]  high_nib;
        logic [7:0]  rec_count;
        logic [15:0] rec_addr;
        logic [7:0]  byte_idx;
        logic [7:0]  run_sum;
        logic [16:0] chunk_end;
        logic        chunk_nonempty;
        logic        err;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:          PH_LINE_START,
        nib_pend:       1'b0,
        high_nib:       4'd0,
        rec_count:      8'd0,
        rec_addr:       16'd0,
        byte_idx:       8'd0,
        run_sum:        8'd0,
        chunk_end:      17'd0,
        chunk_nonempty: 1'b0,
        err:            1'b0
    };

    typedef struct packed {
        t_status     status;
        logic [7:0]  data_byte;
        logic [16:0] byte_address;
        logic [15:0] record_start;
        logic [7:0]  record_length;
        logic        new_chunk;
        logic        chunk_open;
    } t_result;

    // {valid, value} for one ASCII hex digit, either letter case
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ihex_step.sv @@
// ----------------------------------------------------------------------------
// ihex_step: per-character parse step
// Computes the next parser state and the optional result for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_step (
    input  var ihex_pkg::t_state  i_cur,
    input  wire logic [7:0]       i_char_code,
    input  wire logic             i_end_of_input,
    output ihex_pkg::t_state      o_next,
    output logic                  o_res_valid,
    output ihex_pkg::t_result     o_res
);
    import ihex_pkg::*;

    logic       eol;
    logic [4:0] hv;
    logic [7:0] b;
    logic [7:0] sum_next;
    logic [7:0] idx_next;

    assign eol      = (i_char_code == CHAR_LF) || (i_char_code == CHAR_CR);
    assign hv       = hex_value(i_char_code);
    assign b        = {i_cur.high_nib, hv[3:0]};
    assign sum_next = i_cur.run_sum + b;
    assign idx_next = i_cur.byte_idx + 8'd1;

    always_comb begin
        o_next      = i_cur;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_end_of_input) begin
            o_res_valid = 1'b1;
            if (!i_cur.err && (i_cur.phase inside {[PH_COUNT:PH_CHECK]})) begin
                o_res.status = ST_FMT_ERR;
            end else begin
                o_res.status     = ST_END;
                o_res.chunk_open = !i_cur.err && i_cur.chunk_nonempty;
            end
            o_next = STATE_RESET;
        end else if (i_cur.err) begin
            // hold: everything ignored until end of input
        end else if (i_cur.phase == PH_LINE_START) begin
            if (i_char_code == CHAR_COLON) begin
                o_next.phase    = PH_COUNT;
                o_next.nib_pend = 1'b0;
                o_next.run_sum  = 8'd0;
            end else if (!eol) begin
                o_next.phase = PH_SKIP;
            end
        end else if (i_cur.phase inside {[PH_COUNT:PH_CHECK]}) begin
            if (!hv[4]) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_FMT_ERR;
                o_next.err   = 1'b1;
                o_next.phase = PH_SKIP;
            end else if (!i_cur.nib_pend) begin
                o_next.high_nib = hv[3:0];
                o_next.nib_pend = 1'b1;
            end else begin
                o_next.nib_pend = 1'b0;
                o_next.run_sum  = sum_next;
                case (i_cur.phase)
                    PH_COUNT: begin
                        o_next.rec_count = b;
                        o_next.phase     = PH_ADDR_HI;
                    end
                    PH_ADDR_HI: begin
                        o_next.rec_addr = {b, 8'd0};
                        o_next.phase    = PH_ADDR_LO;
                    end
                    PH_ADDR_LO: begin
                        o_next.rec_addr = {i_cur.rec_addr[15:8], b};
                        o_next.phase    = PH_TYPE;
                    end
                    PH_TYPE: begin
                        o_next.byte_idx = 8'd0;
                        if (b != DATA_KIND) begin
                            o_next.phase = PH_SKIP;
                        end else if (i_cur.rec_count == 8'd0) begin
                            o_next.phase = PH_CHECK;
                        end else begin
                            o_next.phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        o_res_valid        = 1'b1;
                        o_res.status       = ST_DATA;
                        o_res.data_byte    = b;
                        o_res.byte_address = {1'b0, i_cur.rec_addr}
                                           + {9'd0, i_cur.byte_idx};
                        o_next.byte_idx    = idx_next;
                        if (idx_next >= i_cur.rec_count) begin
                            o_next.phase = PH_CHECK;
                        end
                    end
                    default: begin
                        o_res_valid = 1'b1;
                        if (sum_next != 8'd0) begin
                            o_res.status = ST_SUM_ERR;
                            o_next.err   = 1'b1;
                        end else begin
                            o_res.status        = ST_ACCEPT;
                            o_res.record_start  = i_cur.rec_addr;
                            o_res.record_length = i_cur.rec_count;
                            if ({1'b0, i_cur.rec_addr} == i_cur.chunk_end) begin
                                if (i_cur.rec_count != 8'd0) begin
                                    o_next.chunk_nonempty = 1'b1;
                                end
                            end else begin
                                o_res.new_chunk       = 1'b1;
                                o_next.chunk_nonempty = (i_cur.rec_count != 8'd0);
                            end
                            o_next.chunk_end = {1'b0, i_cur.rec_addr}
                                             + {9'd0, i_cur.rec_count};
                        end
                        o_next.phase = PH_SKIP;
                    end
                endcase
            end
        end else begin
            // skip to line end
            if (eol) begin
                o_next.phase = PH_LINE_START;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/ihex_out_reg.sv @@
// ----------------------------------------------------------------------------
// ihex_out_reg: result register
// Holds one result item until the consumer takes it; frees itself in the
// same cycle it is taken so a new item can load.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  var ihex_pkg::t_result i_res,
    input  wire logic             i_out_ready,
    output logic                  o_free,
    output logic                  o_out_valid,
    output ihex_pkg::t_result     o_res
);
    import ihex_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_out_ready;
    assign n_valid = (r_valid && !i_out_ready) || i_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ rtl/intel_hex_record_parser.sv @@
// ----------------------------------------------------------------------------
// intel_hex_record_parser: character-stream hex record parser
// A result appears on the output in the cycle after its item is taken.
// Throughput: one character item per cycle while the result register is free,
// set by the single parse step between the state register and the result register.
// Reset: synchronous, active low; parser returns to waiting for a line start
// and the result register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_end_of_input,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [7:0]       o_data_byte,
    output logic [16:0]      o_byte_address,
    output logic [15:0]      o_record_start,
    output logic [7:0]       o_record_length,
    output logic             o_new_chunk,
    output logic             o_chunk_open
);
    import ihex_pkg::*;

    // Parser state: phase, partial byte, record header fields, running
    // checksum, chunk tracking and the sticky error flag.
    t_state  r_state;
    t_state  n_state;

    t_result step_res;
    t_result out_res;
    logic    step_res_valid;
    logic    accept;
    logic    free;

    // Take an item whenever the result register is empty or being drained;
    // hold the input while a result waits and the receiver stalls.
    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    // One character's worth of work: hex decode, field assembly, checksum,
    // data byte emission, record acceptance and chunk continuity.
    ihex_step u_step (
        .i_cur          (r_state),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_next         (n_state),
        .o_res_valid    (step_res_valid),
        .o_res          (step_res)
    );

    // Advance the parser state only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Load the result register only when the item produced a result.
    ihex_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && step_res_valid),
        .i_res       (step_res),
        .i_out_ready (i_out_ready),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_status        = out_res.status;
    assign o_data_byte     = out_res.data_byte;
    assign o_byte_address  = out_res.byte_address;
    assign o_record_start  = out_res.record_start;
    assign o_record_length = out_res.record_length;
    assign o_new_chunk     = out_res.new_chunk;
    assign o_chunk_open    = out_res.chunk_open;

endmodule

`default_nettype wire

@@ tb/tb_intel_hex_record_parser.sv @@
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser: self-checking bench for the hex record parser
// Feeds hex record text one character per item (well-formed records with
// random content, flawed records, noise lines and end-of-input markers),
// predicts every result from a parser model of its own, and compares each
// result field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int RANDOM_CHARS   = 1810;  // characters in the random part
    localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 8;

    // how a generated record is damaged, if at all
    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,    // checksum byte off by a nonzero amount
        FLAW_DIGIT,  // one digit replaced by a non-hex character
        FLAW_SHORT,  // line ends before the checksum is complete
        FLAW_EOF     // text ends in the middle of the record
    } t_flaw;

    typedef struct packed {
        logic [7:0] code;
        logic       eoi;
    } t_char_item;

    // ------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_char_code    = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic [7:0]  o_data_byte;
    logic [16:0] o_byte_address;
    logic [15:0] o_record_start;
    logic [7:0]  o_record_length;
    logic        o_new_chunk;
    logic        o_chunk_open;

    intel_hex_record_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_end_of_input  (i_end_of_input),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_data_byte     (o_data_byte),
        .o_byte_address  (o_byte_address),
        .o_record_start  (o_record_start),
        .o_record_length (o_record_length),
        .o_new_chunk     (o_new_chunk),
        .o_chunk_open    (o_chunk_open)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_char_item text_chars[$];      // characters waiting to be driven
    t_result    results_due[$];     // predicted results, oldest first
    int         junk_chars = 0;     // characters sent into a dead text
    int         chars_taken = 0;
    int         ends_taken = 0;     // end-of-input markers taken
    int         fail_count = 0;
    int         status_seen[8];
    int         burst_left = 8;
    int         gap_left = 0;
    int         rx_cycle = 0;
    int         hold_left = 0;
    int         idle_cycles = 0;
    t_char_item next_char;
    t_result    want;

    // ------------------------------------------------------------------
    // Parser model: line/field tracking, running sum and chunk tracking
    // ------------------------------------------------------------------
    t_phase      cur_phase;
    logic        half_pending;
    logic [3:0]  upper_nib;
    logic [7:0]  rec_len;
    logic [15:0] rec_base;
    logic [7:0]  data_idx;
    logic [7:0]  cksum;
    logic [16:0] chunk_tail;        // first address past the open chunk
    logic        chunk_has_data;
    logic        text_failed;       // error latched until end of input

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    task automatic clear_parser();
        cur_phase      = PH_LINE_START;
        half_pending   = 1'b0;
        upper_nib      = 4'd0;
        rec_len        = 8'd0;
        rec_base       = 16'd0;
        data_idx       = 8'd0;
        cksum          = 8'd0;
        chunk_tail     = 17'd0;
        chunk_has_data = 1'b0;
        text_failed    = 1'b0;
    endtask

    // advance the model by one accepted character; queue any result it causes
    task automatic parse_char(input logic [7:0] c, input logic eoi);
        t_result r;
        int      v;
        logic [7:0] b;
        logic    line_end;
        r = '0;
        line_end = (c == CHAR_LF) || (c == CHAR_CR);

        if (eoi) begin
            // an unfinished record is a format error, else report chunk state
            if (!text_failed && cur_phase >= PH_COUNT && cur_phase <= PH_CHECK) begin
                r.status = ST_FMT_ERR;
            end else begin
                r.status     = ST_END;
                r.chunk_open = !text_failed && chunk_has_data;
            end
            results_due.push_back(r);
            clear_parser();
            return;
        end
        if (text_failed) return;

        if (cur_phase == PH_LINE_START) begin
            if (c == CHAR_COLON) begin
                cur_phase    = PH_COUNT;
                half_pending = 1'b0;
                cksum        = 8'd0;
            end else if (!line_end) begin
                cur_phase = PH_SKIP;
            end
            return;
        end
        if (cur_phase == PH_SKIP) begin
            if (line_end) cur_phase = PH_LINE_START;
            return;
        end

        // inside the record fields: only hex digits are legal
        v = hex_digit(c);
        if (v < 0) begin
            r.status    = ST_FMT_ERR;
            text_failed = 1'b1;
            cur_phase   = PH_SKIP;
            results_due.push_back(r);
            return;
        end
        if (!half_pending) begin
            upper_nib    = v[3:0];
            half_pending = 1'b1;
            return;
        end
        half_pending = 1'b0;
        b = {upper_nib, v[3:0]};
        cksum = cksum + b;

        case (cur_phase)
            PH_COUNT: begin
                rec_len   = b;
                cur_phase = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
                rec_base  = {b, 8'd0};
                cur_phase = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
                rec_base[7:0] = b;
                cur_phase     = PH_TYPE;
            end
            PH_TYPE: begin
                data_idx = 8'd0;
                // only data records are parsed further; the rest skip the line
                if (b != DATA_KIND) cur_phase = PH_SKIP;
                else cur_phase = (rec_len == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                r.status       = ST_DATA;
                r.data_byte    = b;
                r.byte_address = {1'b0, rec_base} + {9'd0, data_idx};
                results_due.push_back(r);
                data_idx = data_idx + 8'd1;
                if (data_idx >= rec_len) cur_phase = PH_CHECK;
            end
            default: begin
                if (cksum != 8'd0) begin
                    r.status    = ST_SUM_ERR;
                    text_failed = 1'b1;
                end else begin
                    r.status        = ST_ACCEPT;
                    r.record_start  = rec_base;
                    r.record_length = rec_len;
                    if ({1'b0, rec_base} == chunk_tail) begin
                        r.new_chunk = 1'b0;
                        if (rec_len != 8'd0) chunk_has_data = 1'b1;
                    end else begin
                        r.new_chunk    = 1'b1;
                        chunk_has_data = (rec_len != 8'd0);
                    end
                    chunk_tail = {1'b0, rec_base} + {9'd0, rec_len};
                end
                cur_phase = PH_SKIP;
                results_due.push_back(r);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c);
        text_chars.push_back('{code: c, eoi: 1'b0});
    endtask

    // end of text; the character code is random since it is ignored
    task automatic push_end();
        text_chars.push_back('{code: 8'($urandom_range(0, 255)), eoi: 1'b1});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return ($urandom_range(0, 1) ? "A" : "a") + (n - 4'd10);
    endfunction

    function automatic logic [7:0] bad_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
        return c;
    endfunction

    // random printable-or-not character that does not end a line
    function automatic logic [7:0] line_filler();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_LF || c == CHAR_CR) c = "#";
        return c;
    endfunction

    task automatic push_line_end();
        int n;
        case ($urandom_range(0, 4))
            0: push_char(CHAR_LF);
            1: push_char(CHAR_CR);
            2: begin
                push_char(CHAR_CR);
                push_char(CHAR_LF);
            end
            3: begin
                // trailing text after the checksum is ignored
                n = $urandom_range(1, 4);
                repeat (n) push_char(line_filler());
                push_char(CHAR_LF);
            end
            default: begin
                push_char(CHAR_LF);
                push_char(CHAR_LF);
            end
        endcase
    endtask

    // close a text after an error: up to three ignored characters, then the end
    task automatic kill_text();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) push_char(8'($urandom_range(0, 255)));
        junk_chars += n;
        push_end();
    endtask

    task automatic emit_record(input logic [7:0] count, input logic [15:0] addr,
                               input logic [7:0] kind, input t_flaw flaw);
        logic [7:0] rec_bytes[$];
        logic [7:0] sum;
        logic [7:0] cur_byte;
        int         ndig;
        int         flaw_at;
        rec_bytes.push_back(count);
        rec_bytes.push_back(addr[15:8]);
        rec_bytes.push_back(addr[7:0]);
        rec_bytes.push_back(kind);
        for (int i = 0; i < int'(count); i++) rec_bytes.push_back(8'($urandom_range(0, 255)));
        sum = 8'd0;
        foreach (rec_bytes[k]) sum = sum + rec_bytes[k];
        sum = 8'd0 - sum;
        if (flaw == FLAW_SUM) sum = sum + 8'($urandom_range(1, 255));
        rec_bytes.push_back(sum);

        ndig    = 2 * rec_bytes.size();
        flaw_at = $urandom_range(0, ndig - 1);
        push_char(CHAR_COLON);
        for (int i = 0; i < ndig; i++) begin
            if ((flaw == FLAW_SHORT || flaw == FLAW_EOF) && i == flaw_at) break;
            cur_byte = rec_bytes[i / 2];
            if (flaw == FLAW_DIGIT && i == flaw_at) push_char(bad_digit());
            else push_char(hex_char(i[0] ? cur_byte[3:0] : cur_byte[7:4]));
        end
        case (flaw)
            FLAW_EOF:   push_end();
            FLAW_SHORT: push_char($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
            default:    push_line_end();
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] next_addr;
        logic [15:0] addr;
        logic [7:0]  count;
        int          pick;
        int          n;

        clear_parser();

        // Directed: extreme characters on a skipped line, a record at the top
        // of the address space with mixed-case digits, end with a chunk open.
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CHAR_LF);
        push_text(":01FFFF00aB56");
        push_char(CHAR_CR);
        push_char(CHAR_LF);
        push_end();
        // bad digit, then ignored text, then end with the error latched
        push_text(":0Gx");
        push_end();
        // record left unfinished at end of input
        push_text(":0");
        push_end();
        // empty record at address zero continues the empty chunk; trailing text
        push_text(":0000000000 zz");
        push_char(CHAR_LF);
        // short line
        push_text(":00");
        push_char(CHAR_LF);
        push_end();

        // Random texts: mostly well-formed data records, with the rest split
        // among other record types, damaged records, noise lines and ends.
        next_addr = 16'd0;
        while (text_chars.size() - junk_chars < RANDOM_CHARS + 40) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                count = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(128, 255))
                                                     : 8'($urandom_range(0, 16));
                n = $urandom_range(0, 9);
                if (n < 5) addr = next_addr;
                else if (n < 8) addr = 16'($urandom_range(0, 65535));
                else if (n == 8) addr = 16'hFFFF - 16'($urandom_range(0, 20));
                else addr = 16'($urandom_range(0, 8));
                emit_record(count, addr, DATA_KIND, FLAW_NONE);
                next_addr = addr + {8'd0, count};
            end else if (pick < 65) begin
                emit_record(8'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(1, 255)), FLAW_NONE);
            end else if (pick < 72) begin
                emit_record(8'($urandom_range(0, 8)), next_addr, DATA_KIND, FLAW_SUM);
                kill_text();
                next_addr = 16'd0;
            end else if (pick < 78) begin
                emit_record(8'($urandom_range(0, 8)), next_addr, DATA_KIND, FLAW_DIGIT);
                kill_text();
                next_addr = 16'd0;
            end else if (pick < 83) begin
                emit_record(8'($urandom_range(0, 8)), next_addr, DATA_KIND, FLAW_SHORT);
                kill_text();
                next_addr = 16'd0;
            end else if (pick < 86) begin
                emit_record(8'($urandom_range(0, 8)), next_addr, DATA_KIND, FLAW_EOF);
                next_addr = 16'd0;
            end else if (pick < 93) begin
                if ($urandom_range(0, 2) == 0) begin
                    // blank line
                    push_char(CHAR_CR);
                    push_char(CHAR_LF);
                end else begin
                    // line that does not open with a colon is skipped whole
                    push_char($urandom_range(0, 1) ? line_filler() : "#");
                    if (text_chars[$].code == CHAR_COLON) text_chars[$].code = "#";
                    n = $urandom_range(0, 10);
                    repeat (n) push_char(line_filler());
                    push_char(CHAR_LF);
                end
            end else begin
                push_end();
                next_addr = 16'd0;
            end
        end
        push_end();

        // hold reset, then release it on a clock edge
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the last character to go in and the last result to come out
        wait (text_chars.size() == 0 && !i_in_valid);
        wait (results_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (results_due.size() != 0) begin
            $error("%0d results never arrived", results_due.size());
            fail_count += results_due.size();
        end
        $display("Parsed %0d character items over %0d texts.", chars_taken, ends_taken);
        $display("Results: %0d data, %0d accepted, %0d format err, %0d sum err, %0d ends.",
                 status_seen[ST_DATA], status_seen[ST_ACCEPT], status_seen[ST_FMT_ERR],
                 status_seen[ST_SUM_ERR], status_seen[ST_END]);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps; hold the item until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                parse_char(i_char_code, i_end_of_input);
                chars_taken++;
                if (i_end_of_input) ends_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (text_chars.size() > 0) begin
                    next_char = text_chars.pop_front();
                    i_char_code    <= next_char.code;
                    i_end_of_input <= next_char.eoi;
                    i_in_valid     <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // now and then a long stretch with no gaps at all
                        if ($urandom_range(0, 9) == 0) begin
                            burst_left = $urandom_range(150, 400);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                      : $urandom_range(1, 10);
                        end
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: four stall patterns taken in turn, plus two long
    // hold-offs so the result register fills and back-pressures the input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle == 400 || rx_cycle == 1600) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_cycle[9:8])
                2'd0: i_out_ready <= 1'b1;
                2'd1: i_out_ready <= 1'($urandom_range(0, 1));
                2'd2: i_out_ready <= (rx_cycle[2:0] != 3'd0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result with none expected: status %0d", o_status);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("byte_address", want.byte_address, o_byte_address);
                check_field("record_start", want.record_start, o_record_start);
                check_field("record_length", want.record_length, o_record_length);
                check_field("new_chunk", want.new_chunk, o_new_chunk);
                check_field("chunk_open", want.chunk_open, o_chunk_open);
            end
            if (!$isunknown(o_status)) status_seen[o_status]++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run if neither channel moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

@@ files.f @@
rtl/ihex_pkg.sv
rtl/ihex_step.sv
rtl/ihex_out_reg.sv
rtl/intel_hex_record_parser.sv
tb/tb_intel_hex_record_parser.sv
